// ----- src/dip_pkg.sv -----
// ----------------------------------------------------------------------------
// dip_pkg
// Types and character codes shared by the dotted IPv4 address parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dip_pkg;

    localparam int CHAR_W = 8;
    localparam int ADDR_W = 32;
    localparam int LEAD_N = 3;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

    localparam logic [ADDR_W-1:0] MAX_8  = 32'h0000_00ff;
    localparam logic [ADDR_W-1:0] MAX_16 = 32'h0000_ffff;
    localparam logic [ADDR_W-1:0] MAX_24 = 32'h00ff_ffff;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } radix_t;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_ZERO   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_TAIL   = 3'd3,
        PH_ERROR  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [ADDR_W-1:0]             accum;
        radix_t                        radix;
        logic [LEAD_N-1:0][7:0]        lead;
        logic [1:0]                    part_count;
        phase_t                        phase;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        accum:      '0,
        radix:      RX_DEC,
        lead:       '0,
        part_count: 2'd0,
        phase:      PH_START
    };

endpackage

`default_nettype wire

// ----- src/dip_step.sv -----
// ----------------------------------------------------------------------------
// dip_step
// One character of parsing: next parser state, plus the result at NUL.
// ----------------------------------------------------------------------------
`default_nettype none

module dip_step (
    input  wire dip_pkg::parse_state_t          cur,
    input  wire logic [dip_pkg::CHAR_W-1:0]     char_code,
    output dip_pkg::parse_state_t               nxt,
    output logic                                valid_res,
    output logic [dip_pkg::ADDR_W-1:0]          address
);
    import dip_pkg::*;

    parse_state_t        pre;
    logic                do_digit;
    logic                is_dec;
    logic                is_lhex;
    logic                is_uhex;
    logic                is_ws;
    logic [3:0]          dval;
    logic [ADDR_W-1:0]   acc_x8;
    logic [ADDR_W-1:0]   acc_x10;
    logic [ADDR_W-1:0]   acc_x16;
    logic [ADDR_W-1:0]   v;

    assign is_dec  = (char_code >= CH_0) && (char_code <= CH_9);
    assign is_lhex = (char_code >= CH_LA) && (char_code <= CH_LF);
    assign is_uhex = (char_code >= CH_UA) && (char_code <= CH_UF);
    assign is_ws   = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));

    // prefix handling, then optional digit step on pre
    always_comb
    begin
        pre      = cur;
        do_digit = 1'b0;
        unique case (cur.phase)
            PH_START:
            begin
                pre.accum = '0;
                if (char_code == CH_0)
                begin
                    pre.radix = RX_OCT;
                    pre.phase = PH_ZERO;
                end
                else
                begin
                    pre.radix = RX_DEC;
                    pre.phase = PH_DIGITS;
                    do_digit  = 1'b1;
                end
            end
            PH_ZERO:
            begin
                pre.phase = PH_DIGITS;
                if ((char_code == CH_LX) || (char_code == CH_UX))
                begin
                    pre.radix = RX_HEX;
                end
                else
                begin
                    pre.radix = RX_OCT;
                    do_digit  = 1'b1;
                end
            end
            PH_DIGITS: do_digit = 1'b1;
            PH_TAIL:   ;
            default:   pre.phase = PH_ERROR;
        endcase
    end

    assign acc_x8  = {pre.accum[ADDR_W-4:0], 3'b000};
    assign acc_x16 = {pre.accum[ADDR_W-5:0], 4'b0000};
    assign acc_x10 = acc_x8 + {pre.accum[ADDR_W-2:0], 1'b0};

    always_comb
    begin
        dval = char_code[3:0];
        if (is_lhex || is_uhex)
        begin
            dval = char_code[3:0] + 4'd9;
        end
    end

    always_comb
    begin
        nxt = pre;
        if (char_code == CH_NUL)
        begin
            nxt = STATE_CLEAR;
        end
        else if (do_digit)
        begin
            if (is_dec)
            begin
                case (pre.radix)
                    RX_OCT:  nxt.accum = acc_x8 + {28'd0, dval};
                    RX_HEX:  nxt.accum = acc_x16 + {28'd0, dval};
                    default: nxt.accum = acc_x10 + {28'd0, dval};
                endcase
            end
            else if ((pre.radix == RX_HEX) && (is_lhex || is_uhex))
            begin
                nxt.accum = acc_x16 + {28'd0, dval};
            end
            else if (char_code == CH_DOT)
            begin
                if ((pre.part_count == 2'd3) || (pre.accum > MAX_8))
                begin
                    nxt.phase = PH_ERROR;
                end
                else
                begin
                    case (pre.part_count)
                        2'd0:    nxt.lead[0] = pre.accum[7:0];
                        2'd1:    nxt.lead[1] = pre.accum[7:0];
                        default: nxt.lead[2] = pre.accum[7:0];
                    endcase
                    nxt.part_count = pre.part_count + 2'd1;
                    nxt.accum      = '0;
                    nxt.radix      = RX_DEC;
                    nxt.phase      = PH_START;
                end
            end
            else if (is_ws)
            begin
                nxt.phase = PH_TAIL;
            end
            else
            begin
                nxt.phase = PH_ERROR;
            end
        end
    end

    // end-of-string result
    always_comb
    begin
        v         = cur.accum;
        valid_res = 1'b1;
        case (cur.part_count)
            2'd0: ;
            2'd1:
            begin
                valid_res = (cur.accum <= MAX_24);
                v = {cur.lead[0], cur.accum[23:0]};
            end
            2'd2:
            begin
                valid_res = (cur.accum <= MAX_16);
                v = {cur.lead[0], cur.lead[1], cur.accum[15:0]};
            end
            default:
            begin
                valid_res = (cur.accum <= MAX_8);
                v = {cur.lead[0], cur.lead[1], cur.lead[2], cur.accum[7:0]};
            end
        endcase
        if ((cur.phase != PH_START) && (cur.phase != PH_ZERO) &&
            (cur.phase != PH_DIGITS) && (cur.phase != PH_TAIL))
        begin
            valid_res = 1'b0;
        end
        address = valid_res ? v : '0;
    end

endmodule

`default_nettype wire

// ----- src/dotted_ipv4_address_parser_top.sv -----
// ----------------------------------------------------------------------------
// dotted_ipv4_address_parser_top
// Streaming parser for textual IPv4 addresses (a, a.b, a.b.c, a.b.c.d).
//
// Input channel in_valid/in_ready carries one character per transfer on
// char_code; a NUL character ends the string. Output channel
// out_valid/out_ready carries one result per string (valid_res, address),
// produced only for the NUL transfer.
// A character is registered on accept and parsed in the following cycle
// against the parser state; a NUL result is loaded into the output register
// at the end of that cycle, which raises out_valid. Throughput is one character
// per cycle, set by the single state update per character, while no NUL waits.
// When the receiver stalls, non-NUL characters keep flowing; a NUL waits in
// the input register until the output register is free, and input stalls
// behind it. Reset clears the parser state and the valid flags of the input
// and output registers; the block then accepts a fresh string.
// ----------------------------------------------------------------------------
`default_nettype none

module dotted_ipv4_address_parser_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [dip_pkg::CHAR_W-1:0]     char_code,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                valid_res,
    output logic [dip_pkg::ADDR_W-1:0]          address
);
    import dip_pkg::*;

    logic                in_valid_reg;
    logic [CHAR_W-1:0]   char_reg;
    parse_state_t        state_reg;
    parse_state_t        state_next;
    logic                out_valid_reg;
    logic                valid_res_reg;
    logic [ADDR_W-1:0]   address_reg;
    logic                step_valid;
    logic [ADDR_W-1:0]   step_address;
    logic                is_nul;
    logic                advance;

    assign is_nul   = (char_reg == CH_NUL);
    assign advance  = in_valid_reg && (!is_nul || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    dip_step u_step (
        .cur       (state_reg),
        .char_code (char_reg),
        .nxt       (state_next),
        .valid_res (step_valid),
        .address   (step_address)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance && is_nul)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= char_code;
        end
        if (advance && is_nul)
        begin
            valid_res_reg <= step_valid;
            address_reg   <= step_address;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;
    assign address   = address_reg;

endmodule

`default_nettype wire

// ----- bench/ipv4_parse_checker.sv -----
// ----------------------------------------------------------------------------
// ipv4_parse_checker
// Watches both channels of the dotted IPv4 address parser. Every character
// transfer runs through a local parse model; each NUL queues the expected
// (valid_res, address) pair, and every output transfer is compared with the
// oldest queued pair. Mismatches and unexpected results are counted.
// ----------------------------------------------------------------------------
module ipv4_parse_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [dip_pkg::CHAR_W-1:0]  char_code,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        valid_res,
    input  logic [dip_pkg::ADDR_W-1:0]  address,
    output int                          fail_count,
    output int                          pending,
    output int                          n_chars,
    output int                          n_results,
    output int                          n_valid
);
    timeunit 1ns;
    timeprecision 1ps;

    import dip_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] addr;
    } addr_result_t;

    addr_result_t        addr_q[$];

    logic [ADDR_W-1:0]   acc;
    radix_t              rdx;
    logic [7:0]          lead_part [LEAD_N];
    logic [1:0]          part_cnt;
    phase_t              ph;

    task automatic clear_parse();
        acc      = '0;
        rdx      = RX_DEC;
        for (int i = 0; i < LEAD_N; i++)
            lead_part[i] = 8'd0;
        part_cnt = 2'd0;
        ph       = PH_START;
    endtask

    task automatic take_digit(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
        begin
            case (rdx)
                RX_OCT:  acc = (acc << 3) + (c - CH_0);
                RX_HEX:  acc = (acc << 4) + (c - CH_0);
                default: acc = acc * 32'd10 + (c - CH_0);
            endcase
        end
        else if (rdx == RX_HEX && c >= CH_LA && c <= CH_LF)
            acc = (acc << 4) + (c - CH_LA + 32'd10);
        else if (rdx == RX_HEX && c >= CH_UA && c <= CH_UF)
            acc = (acc << 4) + (c - CH_UA + 32'd10);
        else if (c == CH_DOT)
        begin
            if (part_cnt == 2'd3 || acc > MAX_8)
                ph = PH_ERROR;
            else
            begin
                lead_part[part_cnt] = acc[7:0];
                part_cnt = part_cnt + 2'd1;
                acc = '0;
                rdx = RX_DEC;
                ph  = PH_START;
            end
        end
        else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
            ph = PH_TAIL;
        else
            ph = PH_ERROR;
    endtask

    // NUL: assemble the address from the leading parts and the last part
    task automatic close_string();
        addr_result_t r;
        r.ok   = 1'b0;
        r.addr = '0;
        if (ph <= PH_TAIL)
        begin
            case (part_cnt)
                2'd0:
                begin
                    r.ok   = 1'b1;
                    r.addr = acc;
                end
                2'd1:
                    if (acc <= MAX_24)
                    begin
                        r.ok   = 1'b1;
                        r.addr = acc | {lead_part[0], 24'd0};
                    end
                2'd2:
                    if (acc <= MAX_16)
                    begin
                        r.ok   = 1'b1;
                        r.addr = acc | {lead_part[0], lead_part[1], 16'd0};
                    end
                default:
                    if (acc <= MAX_8)
                    begin
                        r.ok   = 1'b1;
                        r.addr = acc | {lead_part[0], lead_part[1], lead_part[2], 8'd0};
                    end
            endcase
        end
        addr_q.push_back(r);
        clear_parse();
    endtask

    task automatic parse_char(input logic [7:0] c);
        if (c == CH_NUL)
            close_string();
        else
        begin
            case (ph)
                PH_START:
                begin
                    acc = '0;
                    if (c == CH_0)
                    begin
                        rdx = RX_OCT;
                        ph  = PH_ZERO;
                    end
                    else
                    begin
                        rdx = RX_DEC;
                        ph  = PH_DIGITS;
                        take_digit(c);
                    end
                end
                PH_ZERO:
                begin
                    ph = PH_DIGITS;
                    if (c == CH_LX || c == CH_UX)
                        rdx = RX_HEX;
                    else
                    begin
                        rdx = RX_OCT;
                        take_digit(c);
                    end
                end
                PH_DIGITS: take_digit(c);
                PH_TAIL:   ;
                default:   ph = PH_ERROR;
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            addr_q.delete();
            fail_count = 0;
            pending    = 0;
            n_chars    = 0;
            n_results  = 0;
            n_valid    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (addr_q.size() == 0)
                begin
                    $error("unexpected result transfer: valid_res %0d address %h",
                           valid_res, address);
                    fail_count++;
                end
                else
                begin
                    addr_result_t exp_r;
                    exp_r = addr_q.pop_front();
                    if (exp_r.ok)
                        n_valid++;
                    if (valid_res !== exp_r.ok)
                    begin
                        $error("valid_res mismatch: expected %0d, actual %0d",
                               exp_r.ok, valid_res);
                        fail_count++;
                    end
                    if (address !== exp_r.addr)
                    begin
                        $error("address mismatch: expected %h, actual %h",
                               exp_r.addr, address);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                n_chars++;
                parse_char(char_code);
            end
            pending = addr_q.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Top of the dotted IPv4 address parser bench. Sends a directed set of
// address strings, then random well-formed, broken and noise strings under
// three pacing regimes and one long output hold; the checker predicts and
// compares every result and the verdict is taken from its failure count.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dip_pkg::*;

    localparam int ITEMS        = 1900;
    localparam int PHASE_ITEMS  = ITEMS / 3;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT        = 300000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [CHAR_W-1:0]   char_code;
    logic                out_valid;
    logic                out_ready;
    logic                valid_res;
    logic [ADDR_W-1:0]   address;

    int                  tx_idle_pct = 25;
    int                  rx_idle_pct = 64;
    logic                hold_on = 1'b0;
    int                  n_sent = 0;
    int                  cycle_cnt;

    int                  fail_count;
    int                  pending;
    int                  n_chars;
    int                  n_results;
    int                  n_valid;

    logic [7:0]          str_q[$];

    always #5 clk = ~clk;

    dotted_ipv4_address_parser_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res),
        .address   (address)
    );

    ipv4_parse_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .valid_res  (valid_res),
        .address    (address),
        .fail_count (fail_count),
        .pending    (pending),
        .n_chars    (n_chars),
        .n_results  (n_results),
        .n_valid    (n_valid)
    );

    // receiver: random stalls, plus one long hold once hold_on is raised
    initial
    begin
        int hold_cnt;
        hold_cnt  = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_on && hold_cnt < HOLD_CYCLES)
            begin
                out_ready = 1'b0;
                hold_cnt++;
            end
            else
                out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_char(input logic [7:0] c);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid  = 1'b0;
            char_code = 8'($urandom_range(0, 255));
            @(negedge clk);
        end
        in_valid  = 1'b1;
        char_code = c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic send_string();
        foreach (str_q[i])
            send_char(str_q[i]);
        str_q.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            str_q.push_back(s[i]);
        str_q.push_back(CH_NUL);
        send_string();
    endtask

    task automatic put_num(input logic [31:0] v, input int unsigned base);
        logic [7:0]  dq[$];
        logic [31:0] t;
        int unsigned d;
        t = v;
        while (t != 0)
        begin
            d = t % base;
            if (d < 10)
                dq.push_front(8'(CH_0 + d));
            else
                dq.push_front(8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + d - 10));
            t = t / base;
        end
        foreach (dq[i])
            str_q.push_back(dq[i]);
    endtask

    task automatic put_part(input logic [31:0] v);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                if (v == 0)
                    str_q.push_back(CH_0);
                else
                    put_num(v, 10);
            4, 5:
            begin
                str_q.push_back(CH_0);
                put_num(v, 8);
            end
            6, 7:
            begin
                str_q.push_back(CH_0);
                str_q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                put_num(v, 16);
            end
            8:
            begin
                // octal form with random 0-9 digits, so stray 8/9 digits may appear
                str_q.push_back(CH_0);
                repeat ($urandom_range(1, 3))
                    str_q.push_back(8'(CH_0 + $urandom_range(0, 9)));
            end
            default: ;
        endcase
    endtask

    task automatic put_address();
        int          n;
        int          w;
        bit          long_run;
        logic [31:0] lim;
        logic [31:0] v;
        n        = $urandom_range(1, 4);
        long_run = 1'b0;
        for (int i = 1; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                v = $urandom_range(256, 4095);
            else
                v = $urandom_range(0, 255);
            put_part(v);
            str_q.push_back(CH_DOT);
        end
        case (n)
            1:       lim = '1;
            2:       lim = MAX_24;
            3:       lim = MAX_16;
            default: lim = MAX_8;
        endcase
        case ($urandom_range(0, 5))
            0: v = lim;
            1: v = lim + 32'd1;
            2: v = $urandom_range(0, 255);
            3:
            begin
                long_run = 1'b1;
                repeat ($urandom_range(10, 12))
                    str_q.push_back(8'(CH_0 + $urandom_range(1, 9)));
            end
            default: v = $urandom & lim;
        endcase
        if (!long_run)
            put_part(v);
        if ($urandom_range(0, 4) == 0)
        begin
            w = $urandom_range(0, 5);
            str_q.push_back((w == 5) ? CH_SPACE : 8'(CH_TAB + w));
            repeat ($urandom_range(0, 4))
                str_q.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic send_random_string();
        int         k;
        int         idx;
        logic [7:0] bad;
        k = $urandom_range(0, 99);
        if (k < 70)
            put_address();
        else if (k < 85)
        begin
            put_address();
            case ($urandom_range(0, 3))
                0:       bad = CH_DOT;
                1:       bad = CH_LX;
                2:       bad = CH_UX;
                default: bad = 8'($urandom_range(1, 255));
            endcase
            idx = $urandom_range(0, str_q.size());
            if (idx == str_q.size())
                str_q.push_back(bad);
            else
                str_q.insert(idx, bad);
        end
        else
            repeat ($urandom_range(0, 8))
                str_q.push_back(8'($urandom_range(1, 255)));
        str_q.push_back(CH_NUL);
        send_string();
    endtask

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", LIMIT, pending);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_code = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_text("");
        send_text("0");
        send_text("255.255.255.255");
        send_text("4294967295");
        send_text("4294967296");
        send_text("0xaBcDeF01");
        send_text("0X7f.0x.1");
        send_text("019.08");
        send_text("1..2");
        send_text("...");
        send_text("....");
        send_text("1.16777215");
        send_text("1.16777216");
        send_text("1.2.65535");
        send_text("1.2.3.256");
        send_text("256.1");
        send_text("1.2.3.4.5");
        send_text("10.0.0.1 junk!");
        send_text("7\tq.z");
        send_text("1.2a");
        send_text("0xg");

        while (n_sent < PHASE_ITEMS)
            send_random_string();

        tx_idle_pct = 64;
        rx_idle_pct = 25;
        while (n_sent < 2 * PHASE_ITEMS)
            send_random_string();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_on     = 1'b1;
        while (n_sent < ITEMS)
            send_random_string();

        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d characters and %0d address results, %0d of them valid.",
                 n_chars, n_results, n_valid);
        $display("Pacing: sender/receiver idle 25/64, then 64/25, then none with a %0d-cycle hold.",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
